// File: rtl/core/dbss_pkg.sv
// Shared types and codes for the double-buffered sorted set lookup.
// No dependencies; the top level and dbss_cmp refer to it by scoped names.
package dbss_pkg;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_COMMIT = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_I,
    ST_SORT_KEY,
    ST_SORT_J,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_SRCH,
    ST_SRCH_CMP,
    ST_SRCH_EQ,
    ST_DONE
  } state_t;

  // Result of the shared comparator, operand a against operand b.
  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_t;

  localparam int unsigned CountOutWidth = 11;

endpackage

// File: rtl/core/dbss_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on nothing; used by the top level.
interface dbss_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] data_value;
  modport source (output valid, output cmd, output data_value, input ready);
  modport sink   (input valid, input cmd, input data_value, output ready);
endinterface

interface dbss_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [10:0] active_count;
  logic        status;
  modport source (output valid, output hit, output active_count, output status, input ready);
  modport sink   (input valid, input hit, input active_count, input status, output ready);
endinterface

// File: rtl/core/double_buffered_sorted_set_lookup.sv
// Top level of the double-buffered sorted set lookup: sequencer and bank state.
// Depends on dbss_pkg, dbss_if, dbss_mem and dbss_cmp.
//
//  channel | dir | payload                         | handshake
//  req     | in  | cmd, data_value                 | valid/ready
//  rsp     | out | hit, active_count, status       | valid/ready
//
// Begin and append update the shadow bank at accept and go straight to the
// result state. A query is a binary search, one probe at a time over the single
// memory port, plus a final equality read. A commit runs an insertion sort
// through the same port on the shadow bank, then swaps banks.
// Reset is synchronous and clears counts, active bank and handshake state;
// memory contents are never cleared. req.ready is low while an item is at
// work and while its result waits for a free response register.
module double_buffered_sorted_set_lookup #(
  parameter int unsigned BANK_DEPTH  = 1024,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input logic               clk,
  input logic               rst,
  dbss_req_if.sink          req,
  dbss_rsp_if.source        rsp
);

  localparam int unsigned AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(BANK_DEPTH + 1);
  localparam logic [CW-1:0] DepthCount = CW'(BANK_DEPTH);

  dbss_pkg::state_t state, state_next;

  // Bank bookkeeping.
  logic          active_bank;
  logic [CW-1:0] count0, count1;
  logic          shadow;
  logic [CW-1:0] scount, acount;

  // Working registers of the sequencer.
  dbss_pkg::cmd_t         cmd;
  logic [VALUE_WIDTH-1:0] key;
  logic [CW-1:0]          idx_i, idx_j;
  logic [CW-1:0]          lo, hi, mid;
  logic                   hit, status;

  // Memory and comparator hookup.
  logic                   mem_we;
  logic [AW:0]            mem_addr;
  logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;
  dbss_pkg::cmp_t         cmp;

  logic req_fire, rsp_free, full;

  assign shadow   = ~active_bank;
  assign scount   = shadow ? count1 : count0;
  assign acount   = active_bank ? count1 : count0;
  assign full     = scount == DepthCount;
  assign mid      = lo + ((hi - lo) >> 1);
  assign req.ready = state == dbss_pkg::ST_IDLE;
  assign req_fire = req.valid && req.ready;
  assign rsp_free = !rsp.valid || rsp.ready;

  dbss_mem #(.ADDR_WIDTH(AW + 1), .VALUE_WIDTH(VALUE_WIDTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Every compare is memory data against the held key.
  dbss_cmp #(.VALUE_WIDTH(VALUE_WIDTH)) u_cmp (
    .a   (mem_rdata),
    .b   (key),
    .res (cmp)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dbss_pkg::ST_IDLE: begin
        if (req_fire) begin
          case (dbss_pkg::cmd_t'(req.cmd))
            dbss_pkg::CMD_COMMIT: state_next = dbss_pkg::ST_SORT_I;
            dbss_pkg::CMD_QUERY:  state_next = dbss_pkg::ST_SRCH;
            default:              state_next = dbss_pkg::ST_DONE;
          endcase
        end
      end
      dbss_pkg::ST_SORT_I:   state_next = (idx_i < scount) ? dbss_pkg::ST_SORT_KEY
                                                           : dbss_pkg::ST_DONE;
      dbss_pkg::ST_SORT_KEY: state_next = dbss_pkg::ST_SORT_J;
      dbss_pkg::ST_SORT_J:   state_next = (idx_j == '0) ? dbss_pkg::ST_SORT_PUT
                                                        : dbss_pkg::ST_SORT_CMP;
      dbss_pkg::ST_SORT_CMP: state_next = cmp.gt ? dbss_pkg::ST_SORT_J
                                                 : dbss_pkg::ST_SORT_PUT;
      dbss_pkg::ST_SORT_PUT: state_next = dbss_pkg::ST_SORT_I;
      dbss_pkg::ST_SRCH: begin
        if (lo < hi) begin
          state_next = dbss_pkg::ST_SRCH_CMP;
        end else if (lo < acount) begin
          state_next = dbss_pkg::ST_SRCH_EQ;
        end else begin
          state_next = dbss_pkg::ST_DONE;
        end
      end
      dbss_pkg::ST_SRCH_CMP: state_next = dbss_pkg::ST_SRCH;
      dbss_pkg::ST_SRCH_EQ:  state_next = dbss_pkg::ST_DONE;
      dbss_pkg::ST_DONE:     state_next = rsp_free ? dbss_pkg::ST_IDLE : dbss_pkg::ST_DONE;
      default:               state_next = dbss_pkg::ST_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {shadow, idx_i[AW-1:0]};
    mem_wdata = key;
    case (state)
      dbss_pkg::ST_IDLE: begin
        // Append writes straight from the request at the next free slot.
        mem_addr  = {shadow, scount[AW-1:0]};
        mem_wdata = req.data_value[VALUE_WIDTH-1:0];
        mem_we    = req_fire && (dbss_pkg::cmd_t'(req.cmd) == dbss_pkg::CMD_APPEND) && !full;
      end
      dbss_pkg::ST_SORT_I:   mem_addr = {shadow, idx_i[AW-1:0]};
      dbss_pkg::ST_SORT_J: begin
        mem_addr = {shadow, AW'(idx_j - 1'b1)};
      end
      dbss_pkg::ST_SORT_CMP: begin
        // Shift the larger neighbor up one slot.
        mem_addr  = {shadow, idx_j[AW-1:0]};
        mem_wdata = mem_rdata;
        mem_we    = cmp.gt;
      end
      dbss_pkg::ST_SORT_PUT: begin
        mem_addr = {shadow, idx_j[AW-1:0]};
        mem_we   = 1'b1;
      end
      dbss_pkg::ST_SRCH: begin
        mem_addr = (lo < hi) ? {active_bank, mid[AW-1:0]} : {active_bank, lo[AW-1:0]};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dbss_pkg::ST_IDLE;
      active_bank <= 1'b0;
      count0      <= '0;
      count1      <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      state <= state_next;
      // Drop a taken result unless a new one loads in its place.
      if (rsp.valid && rsp.ready && (state != dbss_pkg::ST_DONE)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        dbss_pkg::ST_IDLE: begin
          if (req_fire) begin
            cmd    <= dbss_pkg::cmd_t'(req.cmd);
            key    <= req.data_value[VALUE_WIDTH-1:0];
            hit    <= 1'b0;
            status <= (dbss_pkg::cmd_t'(req.cmd) == dbss_pkg::CMD_APPEND) && full;
            idx_i  <= CW'(1);
            lo     <= '0;
            hi     <= acount;
            case (dbss_pkg::cmd_t'(req.cmd))
              dbss_pkg::CMD_BEGIN: begin
                if (shadow) count1 <= '0;
                else        count0 <= '0;
              end
              dbss_pkg::CMD_APPEND: begin
                if (!full) begin
                  if (shadow) count1 <= count1 + 1'b1;
                  else        count0 <= count0 + 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        dbss_pkg::ST_SORT_I: begin
          // Sorted: swap banks.
          if (!(idx_i < scount)) active_bank <= shadow;
        end
        dbss_pkg::ST_SORT_KEY: begin
          key   <= mem_rdata;
          idx_j <= idx_i;
        end
        dbss_pkg::ST_SORT_CMP: begin
          if (cmp.gt) idx_j <= idx_j - 1'b1;
        end
        dbss_pkg::ST_SORT_PUT: begin
          idx_i <= idx_i + 1'b1;
        end
        dbss_pkg::ST_SRCH_CMP: begin
          if (cmp.lt) lo <= mid + 1'b1;
          else        hi <= mid;
        end
        dbss_pkg::ST_SRCH_EQ: begin
          hit <= cmp.eq;
        end
        dbss_pkg::ST_DONE: begin
          if (rsp_free) begin
            rsp.valid        <= 1'b1;
            rsp.hit          <= hit && (cmd == dbss_pkg::CMD_QUERY);
            rsp.active_count <= dbss_pkg::CountOutWidth'(acount);
            rsp.status       <= status;
          end
        end
        default: begin
          hit <= hit;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/dbss_mem.sv
// Single-port value store holding both banks, registered read data.
// Depends on nothing.
module dbss_mem #(
  parameter int unsigned ADDR_WIDTH  = 11,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [ADDR_WIDTH-1:0]  addr,
  input  logic [VALUE_WIDTH-1:0] wdata,
  output logic [VALUE_WIDTH-1:0] rdata
);

  logic [VALUE_WIDTH-1:0] mem [2**ADDR_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/dbss_cmp.sv
// Shared magnitude comparator used by both the sort and the search.
// Depends on dbss_pkg.
module dbss_cmp #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output dbss_pkg::cmp_t         res
);

  assign res.lt = a < b;
  assign res.eq = a == b;
  assign res.gt = a > b;

endmodule

// File: rtl/core/dbss_check.sv
// Port-level checker for the double-buffered sorted set lookup, with its bind.
// Depends on the top level double_buffered_sorted_set_lookup.
module dbss_check (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        hit,
  input logic [10:0] active_count,
  input logic        status
);

  // Hold a stalled response.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({hit, active_count, status}))
    else $error("response changed while stalled");

  // A query hit and a dropped append never come together.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(hit && status))
    else $error("hit and full status both set");

  // One item at a time: busy right after an accept.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accepted a second item while busy");

  // Reset empties the response register.
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind double_buffered_sorted_set_lookup dbss_check u_dbss_check (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .hit          (rsp.hit),
  .active_count (rsp.active_count),
  .status       (rsp.status)
);

// File: sim/tb.sv
// Self-checking testbench for double_buffered_sorted_set_lookup: loads, commits
// and queries against a behavioral bank model. Depends on dbss_pkg and dbss_if.
module tb;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned IDLE_LIMIT = 50000;

  typedef struct {
    dbss_pkg::cmd_t op;
    logic [63:0]    value;
  } req_item_t;

  typedef struct {
    logic        hit;
    logic [10:0] count;
    logic        status;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dbss_req_if req_ch ();
  dbss_rsp_if rsp_ch ();

  double_buffered_sorted_set_lookup #(
    .BANK_DEPTH (DEPTH),
    .VALUE_WIDTH(64)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus waiting to be offered and results waiting to arrive.
  req_item_t      pending_items[$];
  lookup_result_t expected_results[$];

  // Behavioral copy of the two banks.
  logic [63:0] bank_vals[2][DEPTH];
  bit          live_bank;
  int unsigned bank_fill[2];

  // Recently appended values, reused by the generator to make queries hit.
  logic [63:0] recent_vals[$];

  int unsigned errors, items_in, results_out, hits, misses, commits, drops;
  int unsigned idle_cycles;
  bit          req_fire, rsp_fire;

  // Work out the result of one accepted item and advance the bank model.
  task automatic apply_lookup_item(input dbss_pkg::cmd_t op, input logic [63:0] value);
    lookup_result_t r;
    bit          shadow;
    logic [63:0] key;
    int          j;
    r = '{hit: 1'b0, count: '0, status: 1'b0};
    shadow = ~live_bank;
    case (op)
      dbss_pkg::CMD_BEGIN: begin
        bank_fill[shadow] = 0;
      end
      dbss_pkg::CMD_APPEND: begin
        if (bank_fill[shadow] >= DEPTH) begin
          r.status = 1'b1;
          drops++;
        end else begin
          bank_vals[shadow][bank_fill[shadow]] = value;
          bank_fill[shadow]++;
        end
      end
      dbss_pkg::CMD_COMMIT: begin
        // Insertion sort, ascending, duplicates kept.
        for (int i = 1; i < bank_fill[shadow]; i++) begin
          key = bank_vals[shadow][i];
          j = i;
          while (j > 0 && bank_vals[shadow][j-1] > key) begin
            bank_vals[shadow][j] = bank_vals[shadow][j-1];
            j--;
          end
          bank_vals[shadow][j] = key;
        end
        live_bank = shadow;
        commits++;
      end
      default: begin
        for (int i = 0; i < bank_fill[live_bank]; i++)
          if (bank_vals[live_bank][i] == value) r.hit = 1'b1;
        if (r.hit) hits++;
        else misses++;
      end
    endcase
    r.count = bank_fill[live_bank][10:0];
    expected_results.push_back(r);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return 64'($urandom_range(0, 40));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_item(input dbss_pkg::cmd_t op, input logic [63:0] value);
    pending_items.push_back('{op: op, value: value});
    if (op == dbss_pkg::CMD_APPEND) begin
      recent_vals.push_back(value);
      if (recent_vals.size() > 64) void'(recent_vals.pop_front());
    end
  endtask

  // Queries: mostly recently loaded values, some neighbors, some noise.
  task automatic add_query();
    logic [63:0] v;
    if (recent_vals.size() > 0 && $urandom_range(0, 2) != 0) begin
      v = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
      if ($urandom_range(0, 4) == 0) v = v + 64'd1;
    end else begin
      v = rand_word();
    end
    add_item(dbss_pkg::CMD_QUERY, v);
  endtask

  // Sample both channels at the rising edge; predict on accept, check on accept.
  always @(posedge clk) begin
    lookup_result_t want;
    req_fire <= !rst && req_ch.valid && req_ch.ready;
    rsp_fire <= !rst && rsp_ch.valid && rsp_ch.ready;
    if (!rst && req_ch.valid && req_ch.ready) begin
      apply_lookup_item(dbss_pkg::cmd_t'(req_ch.cmd), req_ch.data_value);
      items_in++;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_out++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result hit=%0b count=%0d status=%0b", $realtime,
                 rsp_ch.hit, rsp_ch.active_count, rsp_ch.status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $realtime, want.hit, rsp_ch.hit);
          errors++;
        end
        if (rsp_ch.active_count !== want.count) begin
          $display("%0t: active_count expected %0d actual %0d", $realtime, want.count,
                   rsp_ch.active_count);
          errors++;
        end
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status expected %0b actual %0b", $realtime, want.status,
                   rsp_ch.status);
          errors++;
        end
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 4, gap_left = 0;
  always @(negedge clk) begin
    req_item_t it;
    if (rst) begin
      req_ch.valid      <= 1'b0;
      req_ch.cmd        <= dbss_pkg::CMD_BEGIN;
      req_ch.data_value <= '0;
    end else begin
      if (req_fire) begin
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = $urandom_range(1, 16);
        end
      end
      if (req_ch.valid && !req_fire) begin
        // hold the offered item until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= it.op;
        req_ch.data_value <= it.value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: short random stalls, calm stretches, and one long hold-off.
  int unsigned stall_left = 0, calm_left = 0;
  bit          long_hold_done = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (!long_hold_done && results_out >= 150) begin
        long_hold_done = 1'b1;
        stall_left     = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        rsp_ch.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0: calm_left  = $urandom_range(10, 60);
          1, 2: stall_left = $urandom_range(1, 6);
          default: ;
        endcase
        rsp_ch.ready <= (stall_left == 0);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || req_fire || rsp_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [63:0] v;
    int          n;
    bit          fill_done;
    fill_done = 1'b0;

    // Directed: empty bank, extremes, duplicates, commit and append without begin.
    add_item(dbss_pkg::CMD_QUERY, 64'd5);
    add_item(dbss_pkg::CMD_BEGIN, '1);
    add_item(dbss_pkg::CMD_APPEND, '1);
    add_item(dbss_pkg::CMD_APPEND, 64'd0);
    add_item(dbss_pkg::CMD_APPEND, 64'd5);
    add_item(dbss_pkg::CMD_APPEND, 64'd5);
    add_item(dbss_pkg::CMD_APPEND, 64'h8000_0000_0000_0003);
    add_item(dbss_pkg::CMD_COMMIT, 64'h5555_5555_5555_5555);
    add_item(dbss_pkg::CMD_QUERY, 64'd0);
    add_item(dbss_pkg::CMD_QUERY, '1);
    add_item(dbss_pkg::CMD_QUERY, 64'd5);
    add_item(dbss_pkg::CMD_QUERY, 64'd4);
    add_item(dbss_pkg::CMD_QUERY, 64'h8000_0000_0000_0003);
    add_item(dbss_pkg::CMD_QUERY, 64'h0000_0000_0000_0003);
    add_item(dbss_pkg::CMD_COMMIT, '0);
    add_item(dbss_pkg::CMD_QUERY, 64'd5);
    add_item(dbss_pkg::CMD_APPEND, 64'hAAAA_AAAA_AAAA_AAAA);
    add_item(dbss_pkg::CMD_COMMIT, '0);
    add_item(dbss_pkg::CMD_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
    add_item(dbss_pkg::CMD_QUERY, 64'd5);

    // Random part: mostly well-formed load/commit/query sequences.
    while (pending_items.size() < 540) begin
      if (!fill_done && pending_items.size() > 250) begin
        // One long ascending load with duplicates to give the sort a long pass.
        fill_done = 1'b1;
        add_item(dbss_pkg::CMD_BEGIN, '0);
        v = {$urandom, $urandom} >> 2;
        for (int i = 0; i < 96; i++) begin
          add_item(dbss_pkg::CMD_APPEND, v);
          v = v + $urandom_range(0, 3);
        end
        add_item(dbss_pkg::CMD_COMMIT, '0);
        for (int i = 0; i < 8; i++) add_query();
        add_item(dbss_pkg::CMD_APPEND, v);
        continue;
      end
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            if ($urandom_range(0, 1) == 0) add_query();
            else add_item(dbss_pkg::cmd_t'($urandom_range(0, 3)), rand_word());
          end
        end
        3, 4: begin
          n = $urandom_range(2, 8);
          repeat (n) add_query();
        end
        default: begin
          if ($urandom_range(0, 5) != 0) add_item(dbss_pkg::CMD_BEGIN, rand_word());
          n = $urandom_range(0, 24);
          repeat (n) add_item(dbss_pkg::CMD_APPEND, rand_word());
          add_item(dbss_pkg::CMD_COMMIT, rand_word());
          n = $urandom_range(3, 10);
          repeat (n) add_query();
        end
      endcase
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_items.size() != 0 || req_ch.valid || expected_results.size() != 0);
    repeat (64) @(posedge clk);

    $display("Ran %0d items, %0d results: %0d commits, %0d query hits, %0d misses,",
             items_in, results_out, commits, hits, misses);
    $display("and %0d appends dropped on a full bank.", drops);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/dbss_pkg.sv
rtl/core/dbss_if.sv
rtl/core/dbss_mem.sv
rtl/core/dbss_cmp.sv
rtl/core/double_buffered_sorted_set_lookup.sv
rtl/core/dbss_check.sv
sim/tb.sv
